// ----- design/bgi_pkg.sv -----
// Shared types and codes of the bilinear grid interpolator.
package bgi_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_WRITE_ROW    = 2'd0,
      CMD_WRITE_COLUMN = 2'd1,
      CMD_WRITE_VALUE  = 2'd2,
      CMD_QUERY        = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS_IN_USE = 1'b1;

   // Query sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_ROW,
      ST_SCAN_COL,
      ST_WEIGHTS,
      ST_RD_LO,
      ST_RD_HI,
      ST_MUL_HI,
      ST_ADD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESPOND
   } state_type;

   // Which blend the shared unit works on.
   typedef enum logic [1:0] {
      PASS_COL_LO,
      PASS_COL_HI,
      PASS_FINAL
   } pass_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Commands from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic       mul;
      acc_op_type acc_op;
      logic       div_go;
   } alu_ctl_type;

   // Bound search status.
   typedef struct packed {
      logic have_lo;
      logic have_hi;
   } bound_flags_type;

endpackage

// ----- design/bgi_scan.sv -----
// Bound search unit: tracks nearest lower and upper grid coordinates of a query.
module bgi_scan #(
   parameter int COORD_WIDTH = 16,
   parameter int INDEX_WIDTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          step,
   input  logic [INDEX_WIDTH-1:0]        elem_index,
   input  logic signed [COORD_WIDTH-1:0] elem_coord,
   input  logic signed [COORD_WIDTH-1:0] query,
   output bgi_pkg::bound_flags_type      flags,
   output logic [INDEX_WIDTH-1:0]        lo_index,
   output logic [INDEX_WIDTH-1:0]        hi_index,
   output logic signed [COORD_WIDTH-1:0] lo_coord,
   output logic signed [COORD_WIDTH-1:0] hi_coord
);
   import bgi_pkg::*;

   logic                          have_lo_ff;
   logic                          have_hi_ff;
   logic [INDEX_WIDTH-1:0]        lo_index_ff;
   logic [INDEX_WIDTH-1:0]        hi_index_ff;
   logic signed [COORD_WIDTH-1:0] lo_coord_ff;
   logic signed [COORD_WIDTH-1:0] hi_coord_ff;
   logic                          take_lo;
   logic                          take_hi;

   // Strict compares keep the lowest index among equal coordinates.
   assign take_lo = step && (elem_coord <= query) && (!have_lo_ff || (lo_coord_ff < elem_coord));
   assign take_hi = step && (elem_coord >= query) && (!have_hi_ff || (hi_coord_ff > elem_coord));

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_lo_ff <= 1'b0;
         have_hi_ff <= 1'b0;
      end else begin
         if (take_lo) begin
            have_lo_ff <= 1'b1;
         end
         if (take_hi) begin
            have_hi_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_lo) begin
         lo_index_ff <= elem_index;
         lo_coord_ff <= elem_coord;
      end
      if (take_hi) begin
         hi_index_ff <= elem_index;
         hi_coord_ff <= elem_coord;
      end
   end

   assign flags.have_lo = have_lo_ff;
   assign flags.have_hi = have_hi_ff;
   assign lo_index      = lo_index_ff;
   assign hi_index      = hi_index_ff;
   assign lo_coord      = lo_coord_ff;
   assign hi_coord      = hi_coord_ff;

endmodule

// ----- design/bgi_alu.sv -----
// Shared arithmetic unit: weight multiply, accumulate and bit-serial divide.
module bgi_alu #(
   parameter int COORD_WIDTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bgi_pkg::alu_ctl_type          ctl,
   input  logic [COORD_WIDTH-1:0]        weight,
   input  logic signed [VALUE_WIDTH-1:0] value,
   input  logic [COORD_WIDTH-1:0]        divisor,
   output logic                          div_done,
   output logic signed [VALUE_WIDTH-1:0] quotient
);
   import bgi_pkg::*;

   localparam int PW   = COORD_WIDTH + VALUE_WIDTH + 1;
   localparam int AW   = PW + 1;
   localparam int CNTW = $clog2(VALUE_WIDTH + 1);

   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic signed [AW-1:0]    acc_ff;
   logic signed [AW-1:0]    acc_in;
   logic [AW-1:0]           mag;
   logic [COORD_WIDTH-1:0]  rem_ff;
   logic [VALUE_WIDTH-1:0]  quo_ff;
   logic                    neg_ff;
   logic [CNTW-1:0]         cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [COORD_WIDTH:0]    cand;
   logic [COORD_WIDTH:0]    diff;
   logic                    fits;

   assign prod_in = ctl.mul ? ($signed({1'b0, weight}) * value) : prod_ff;

   always_comb begin
      case (ctl.acc_op)
         ACC_LOAD: acc_in = AW'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + AW'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Magnitude divide; the quotient of a blend always fits VALUE_WIDTH bits,
   // so the upper part of the dividend starts out below the divisor.
   assign mag  = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign cand = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits = cand >= {1'b0, divisor};
   assign diff = cand - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (ctl.div_go) begin
         neg_ff <= acc_ff[AW-1];
         rem_ff <= mag[VALUE_WIDTH +: COORD_WIDTH];
         quo_ff <= mag[VALUE_WIDTH-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[COORD_WIDTH-1:0] : cand[COORD_WIDTH-1:0];
         quo_ff <= {quo_ff[VALUE_WIDTH-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNTW'(1));
         if (ctl.div_go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(VALUE_WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Truncate toward zero: divide magnitudes, then restore the sign.
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign div_done = done_ff;

endmodule

// ----- design/bilinear_grid_interpolator.sv -----
// Top level of the bilinear interpolator over a non-uniform grid.
//
// Usage:
//   Requests arrive on the req_ ports and are taken at a rising edge with
//   start high and busy low. Commands write a row coordinate, a column
//   coordinate or a grid value, or run a query at (req_query_x, req_query_y).
//   A write gives no result; busy stays low.
//   A query raises busy, scans rows_in_use row coordinates and then
//   columns_in_use column coordinates (one per cycle, from registered
//   memories), then runs three blends on one shared multiply and
//   bit-serial divide unit. The result shows on the rsp_ ports for exactly
//   one cycle with rsp_valid; the receiver cannot stall it.
//   Both counts are clamped to the table size. The divider sets one
//   quotient bit per cycle. Busy drops the cycle after the result.
//   csr_ writes set rows_in_use and columns_in_use at any edge; write them
//   only while no query is in flight.
//   Reset clears the counts and the sequencer; table contents are kept
//   and are undefined until written. Busy stays high during reset.
module bilinear_grid_interpolator #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16,
   parameter int COORD_WIDTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_cmd,
   input  logic [$clog2(MAX_ROWS)-1:0]            req_row_index,
   input  logic [$clog2(MAX_COLUMNS)-1:0]         req_column_index,
   input  logic signed [COORD_WIDTH-1:0]          req_grid_coordinate,
   input  logic signed [VALUE_WIDTH-1:0]          req_table_value,
   input  logic signed [COORD_WIDTH-1:0]          req_query_x,
   input  logic signed [COORD_WIDTH-1:0]          req_query_y,
   output logic                                   rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]          rsp_interpolated_value,
   output logic                                   rsp_outside_grid,
   input  logic                                   csr_write_enable,
   input  logic [bgi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [((($clog2(MAX_ROWS + 1)) > ($clog2(MAX_COLUMNS + 1))) ?
                  $clog2(MAX_ROWS + 1) : $clog2(MAX_COLUMNS + 1))-1:0] csr_write_data
);
   import bgi_pkg::*;

   localparam int RIW    = $clog2(MAX_ROWS);
   localparam int CIW    = $clog2(MAX_COLUMNS);
   localparam int RCW    = $clog2(MAX_ROWS + 1);
   localparam int CCW    = $clog2(MAX_COLUMNS + 1);
   localparam int CSR_W  = (RCW > CCW) ? RCW : CCW;
   localparam int IDXW   = CSR_W + 1;
   localparam int SIW    = (RIW > CIW) ? RIW : CIW;
   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int GAW    = $clog2(DEPTH);
   localparam int CW     = COORD_WIDTH;
   localparam int VW     = VALUE_WIDTH;

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic accept;
   logic acc_query;
   logic wr_row;
   logic wr_col;
   logic wr_val;

   assign accept    = start && !busy;
   assign acc_query = accept && (req_cmd == CMD_QUERY);
   // Drop writes whose index lies past the table.
   assign wr_row = accept && (req_cmd == CMD_WRITE_ROW) &&
                   ({1'b0, req_row_index} < (RIW + 1)'(MAX_ROWS));
   assign wr_col = accept && (req_cmd == CMD_WRITE_COLUMN) &&
                   ({1'b0, req_column_index} < (CIW + 1)'(MAX_COLUMNS));
   assign wr_val = accept && (req_cmd == CMD_WRITE_VALUE) &&
                   ({1'b0, req_row_index} < (RIW + 1)'(MAX_ROWS)) &&
                   ({1'b0, req_column_index} < (CIW + 1)'(MAX_COLUMNS));

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [RCW-1:0] rows_in_use_ff;
   logic [CCW-1:0] columns_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff    <= '0;
         columns_in_use_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS_IN_USE:    rows_in_use_ff    <= csr_write_data[RCW-1:0];
            CSR_COLUMNS_IN_USE: columns_in_use_ff <= csr_write_data[CCW-1:0];
            default: ;
         endcase
      end
   end

   // Clamp counts to the table size.
   logic [IDXW-1:0] n_rows;
   logic [IDXW-1:0] n_cols;

   assign n_rows = (rows_in_use_ff > RCW'(MAX_ROWS)) ? IDXW'(MAX_ROWS)
                                                     : IDXW'(rows_in_use_ff);
   assign n_cols = (columns_in_use_ff > CCW'(MAX_COLUMNS)) ? IDXW'(MAX_COLUMNS)
                                                           : IDXW'(columns_in_use_ff);

   // ---------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------
   state_type       state_ff;
   state_type       state_in;
   pass_type        pass_ff;
   pass_type        pass_in;
   logic [IDXW-1:0] idx_ff;
   logic [IDXW-1:0] idx_in;
   logic            step_ff;
   logic            step_in;
   logic [SIW-1:0]  elem_idx_ff;

   logic            in_scan;
   logic [IDXW-1:0] n_cur;
   logic            scan_last;

   assign in_scan   = (state_ff == ST_SCAN_ROW) || (state_ff == ST_SCAN_COL);
   assign n_cur     = (state_ff == ST_SCAN_COL) ? n_cols : n_rows;
   // The read data and its step are registered, so the last element reaches
   // the search unit in the cycle after its read; leave the scan one count past the end.
   assign scan_last = in_scan && (idx_ff == n_cur + IDXW'(1));
   assign idx_in    = (in_scan && !scan_last) ? idx_ff + IDXW'(1) : '0;
   assign step_in   = in_scan && (idx_ff < n_cur);

   // ---------------------------------------------------------------------
   // Coordinate and value memories
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] row_coord_mem [MAX_ROWS];
   logic signed [CW-1:0] col_coord_mem [MAX_COLUMNS];
   logic signed [VW-1:0] grid_mem      [DEPTH];
   logic signed [CW-1:0] row_rd_ff;
   logic signed [CW-1:0] col_rd_ff;
   logic signed [VW-1:0] grid_rd_ff;
   logic [GAW-1:0]       grid_wr_addr;
   logic [GAW-1:0]       grid_rd_addr;

   always_ff @(posedge clock) begin
      if (wr_row) begin
         row_coord_mem[req_row_index] <= req_grid_coordinate;
      end
   end

   always_ff @(posedge clock) begin
      row_rd_ff <= row_coord_mem[idx_ff[RIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_col) begin
         col_coord_mem[req_column_index] <= req_grid_coordinate;
      end
   end

   always_ff @(posedge clock) begin
      col_rd_ff <= col_coord_mem[idx_ff[CIW-1:0]];
   end

   assign grid_wr_addr = GAW'(req_row_index) * GAW'(MAX_COLUMNS) + GAW'(req_column_index);

   always_ff @(posedge clock) begin
      if (wr_val) begin
         grid_mem[grid_wr_addr] <= req_table_value;
      end
   end

   always_ff @(posedge clock) begin
      grid_rd_ff <= grid_mem[grid_rd_addr];
   end

   // ---------------------------------------------------------------------
   // Bound search, shared by both axes
   // ---------------------------------------------------------------------
   logic                 scan_clear;
   logic signed [CW-1:0] scan_query;
   logic signed [CW-1:0] scan_coord;
   bound_flags_type      scan_flags;
   logic [SIW-1:0]       scan_lo_index;
   logic [SIW-1:0]       scan_hi_index;
   logic signed [CW-1:0] scan_lo_coord;
   logic signed [CW-1:0] scan_hi_coord;
   logic signed [CW-1:0] qx_ff;
   logic signed [CW-1:0] qy_ff;

   assign scan_clear = acc_query || ((state_ff == ST_SCAN_ROW) && scan_last);
   assign scan_query = (state_ff == ST_SCAN_COL) ? qy_ff : qx_ff;
   assign scan_coord = (state_ff == ST_SCAN_COL) ? col_rd_ff : row_rd_ff;

   bgi_scan #(
      .COORD_WIDTH (CW),
      .INDEX_WIDTH (SIW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .step       (step_ff),
      .elem_index (elem_idx_ff),
      .elem_coord (scan_coord),
      .query      (scan_query),
      .flags      (scan_flags),
      .lo_index   (scan_lo_index),
      .hi_index   (scan_hi_index),
      .lo_coord   (scan_lo_coord),
      .hi_coord   (scan_hi_coord)
   );

   // Column bounds stay in the search unit until the next query.
   logic                 col_found;
   logic [CIW-1:0]       cl_idx;
   logic [CIW-1:0]       ch_idx;

   assign col_found = scan_flags.have_lo && scan_flags.have_hi;
   assign cl_idx    = scan_lo_index[CIW-1:0];
   assign ch_idx    = scan_hi_index[CIW-1:0];

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   logic                 row_found_ff;
   logic [RIW-1:0]       rl_ff;
   logic [RIW-1:0]       rh_ff;
   logic signed [CW-1:0] rl_coord_ff;
   logic signed [CW-1:0] rh_coord_ff;
   logic [CW-1:0]        wr_lo_ff;
   logic [CW-1:0]        wr_hi_ff;
   logic [CW-1:0]        wr_den_ff;
   logic [CW-1:0]        wc_lo_ff;
   logic [CW-1:0]        wc_hi_ff;
   logic [CW-1:0]        wc_den_ff;
   logic signed [VW-1:0] vcl_ff;
   logic signed [VW-1:0] vch_ff;
   logic signed [VW-1:0] result_ff;
   logic                 outside_ff;

   // Distances to the bounds; a collapsed axis blends as weight one on the
   // lower value over a divisor of one.
   logic signed [CW:0]   r_du;
   logic signed [CW:0]   r_dl;
   logic signed [CW:0]   r_den;
   logic signed [CW:0]   c_du;
   logic signed [CW:0]   c_dl;
   logic signed [CW:0]   c_den;
   logic                 row_collapse;
   logic                 col_collapse;

   assign r_du  = (CW + 1)'(rh_coord_ff) - (CW + 1)'(qx_ff);
   assign r_dl  = (CW + 1)'(qx_ff) - (CW + 1)'(rl_coord_ff);
   assign r_den = (CW + 1)'(rh_coord_ff) - (CW + 1)'(rl_coord_ff);
   assign c_du  = (CW + 1)'(scan_hi_coord) - (CW + 1)'(qy_ff);
   assign c_dl  = (CW + 1)'(qy_ff) - (CW + 1)'(scan_lo_coord);
   assign c_den = (CW + 1)'(scan_hi_coord) - (CW + 1)'(scan_lo_coord);
   assign row_collapse = (rl_ff == rh_ff);
   assign col_collapse = (cl_idx == ch_idx);

   logic                 div_done;
   logic signed [VW-1:0] quotient;

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      elem_idx_ff <= idx_ff[SIW-1:0];
      if (acc_query) begin
         qx_ff <= req_query_x;
         qy_ff <= req_query_y;
      end
      if ((state_ff == ST_SCAN_ROW) && scan_last) begin
         row_found_ff <= scan_flags.have_lo && scan_flags.have_hi;
         rl_ff        <= scan_lo_index[RIW-1:0];
         rh_ff        <= scan_hi_index[RIW-1:0];
         rl_coord_ff  <= scan_lo_coord;
         rh_coord_ff  <= scan_hi_coord;
      end
      if ((state_ff == ST_SCAN_COL) && scan_last) begin
         // Zero result for a point off the grid; cleared on a real result.
         result_ff  <= '0;
         outside_ff <= 1'b1;
      end
      if (state_ff == ST_WEIGHTS) begin
         wr_lo_ff  <= row_collapse ? CW'(1) : r_du[CW-1:0];
         wr_hi_ff  <= row_collapse ? '0     : r_dl[CW-1:0];
         wr_den_ff <= row_collapse ? CW'(1) : r_den[CW-1:0];
         wc_lo_ff  <= col_collapse ? CW'(1) : c_du[CW-1:0];
         wc_hi_ff  <= col_collapse ? '0     : c_dl[CW-1:0];
         wc_den_ff <= col_collapse ? CW'(1) : c_den[CW-1:0];
      end
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         case (pass_ff)
            PASS_COL_LO: vcl_ff <= quotient;
            PASS_COL_HI: vch_ff <= quotient;
            PASS_FINAL: begin
               result_ff  <= quotient;
               outside_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shared arithmetic unit
   // ---------------------------------------------------------------------
   alu_ctl_type          alu_ctl;
   logic [CW-1:0]        alu_weight;
   logic signed [VW-1:0] alu_value;
   logic [CW-1:0]        alu_divisor;
   logic                 final_pass;

   assign final_pass = (pass_ff == PASS_FINAL);

   // Lower product in ST_RD_HI, upper product in ST_MUL_HI.
   always_comb begin
      if (state_ff == ST_RD_HI) begin
         alu_weight = final_pass ? wc_lo_ff : wr_lo_ff;
         alu_value  = final_pass ? vcl_ff   : grid_rd_ff;
      end else begin
         alu_weight = final_pass ? wc_hi_ff : wr_hi_ff;
         alu_value  = final_pass ? vch_ff   : grid_rd_ff;
      end
   end

   assign alu_divisor = final_pass ? wc_den_ff : wr_den_ff;

   bgi_alu #(
      .COORD_WIDTH (CW),
      .VALUE_WIDTH (VW)
   ) u_alu (
      .clock    (clock),
      .reset    (reset),
      .ctl      (alu_ctl),
      .weight   (alu_weight),
      .value    (alu_value),
      .divisor  (alu_divisor),
      .div_done (div_done),
      .quotient (quotient)
   );

   // Grid read: upper row in ST_RD_HI, lower row otherwise; the pass picks
   // the column.
   logic [RIW-1:0] rd_row;
   logic [CIW-1:0] rd_col;

   assign rd_row       = (state_ff == ST_RD_HI) ? rh_ff : rl_ff;
   assign rd_col       = (pass_ff == PASS_COL_HI) ? ch_idx : cl_idx;
   assign grid_rd_addr = GAW'(rd_row) * GAW'(MAX_COLUMNS) + GAW'(rd_col);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_query) begin
               state_in = ST_SCAN_ROW;
            end
         end
         ST_SCAN_ROW: begin
            if (scan_last) begin
               state_in = ST_SCAN_COL;
            end
         end
         ST_SCAN_COL: begin
            if (scan_last) begin
               state_in = (row_found_ff && col_found) ? ST_WEIGHTS : ST_RESPOND;
            end
         end
         ST_WEIGHTS: begin
            state_in = ST_RD_LO;
            pass_in  = PASS_COL_LO;
         end
         ST_RD_LO:    state_in = ST_RD_HI;
         ST_RD_HI:    state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_ADD;
         ST_ADD:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (pass_ff)
                  PASS_COL_LO: begin
                     state_in = ST_RD_LO;
                     pass_in  = PASS_COL_HI;
                  end
                  PASS_COL_HI: begin
                     state_in = ST_RD_LO;
                     pass_in  = PASS_FINAL;
                  end
                  default: state_in = ST_RESPOND;
               endcase
            end
         end
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= PASS_COL_LO;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         idx_ff   <= idx_in;
      end
   end

   // ---------------------------------------------------------------------
   // Outputs and unit commands
   // ---------------------------------------------------------------------
   always_comb begin
      busy      = reset || (state_ff != ST_IDLE);
      rsp_valid = !reset && (state_ff == ST_RESPOND);
      alu_ctl   = '{mul: 1'b0, acc_op: ACC_HOLD, div_go: 1'b0};
      case (state_ff)
         ST_RD_HI: alu_ctl.mul = 1'b1;
         ST_MUL_HI: begin
            alu_ctl.mul    = 1'b1;
            alu_ctl.acc_op = ACC_LOAD;
         end
         ST_ADD:    alu_ctl.acc_op = ACC_ADD;
         ST_DIV_GO: alu_ctl.div_go = 1'b1;
         default: ;
      endcase
   end

   assign rsp_interpolated_value = result_ff;
   assign rsp_outside_grid       = outside_ff;

endmodule

// ----- design/bgi_checker.sv -----
// Port-level checks of the bilinear grid interpolator, bound to the top level.
module bgi_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic [1:0]                             req_cmd,
   input logic                                   rsp_valid,
   input logic signed [VALUE_WIDTH-1:0]          rsp_interpolated_value,
   input logic                                   rsp_outside_grid
);
   import bgi_pkg::*;

   logic query_taken;
   logic write_taken;

   assign query_taken = start && !busy && (req_cmd == CMD_QUERY);
   assign write_taken = start && !busy && (req_cmd != CMD_QUERY);

   // A write completes in its own cycle and leaves no result.
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      write_taken |=> !busy && !rsp_valid)
      else $error("write request produced a result or held busy");

   // A query keeps the block busy through both scans.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_taken |=> (busy && !rsp_valid) ##1 (busy && !rsp_valid)
                      ##1 (busy && !rsp_valid) ##1 (busy && !rsp_valid))
      else $error("query result too early or busy dropped");

   // One strobe per query, then ready again.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outside_grid) |-> (rsp_interpolated_value == '0))
      else $error("point outside grid gave a nonzero value");

endmodule

bind bilinear_grid_interpolator bgi_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_bgi_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .req_cmd                (req_cmd),
   .rsp_valid              (rsp_valid),
   .rsp_interpolated_value (rsp_interpolated_value),
   .rsp_outside_grid       (rsp_outside_grid)
);
